>>> design/lrud_pkg.sv
// Package for the LRU page replacer with dirty marks.
// Shared widths, types and register indexes; no dependencies.
package lrud_pkg;

  localparam int unsigned Frames   = 16;
  localparam int unsigned PageBits = 20;
  localparam int unsigned PageW    = 20;
  localparam int unsigned IdxW     = $clog2(Frames);
  localparam int unsigned CntW     = $clog2(Frames + 1);
  localparam int unsigned CfgW     = 5;
  localparam int unsigned TotW     = 32;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = AddrW - 2;

  localparam logic [RegIdxW-1:0] RegFrameLimit = RegIdxW'(0);

  typedef logic [PageBits-1:0] tag_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [TotW-1:0]     tot_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic look_hit;
  } sts_t;

  typedef struct packed {
    logic             hit;
    logic             evicted_valid;
    logic [PageW-1:0] evicted_page;
    logic             evicted_dirty;
    tot_t             hit_total;
    tot_t             fault_total;
    tot_t             writeback_total;
  } rsp_t;

endpackage

>>> design/lrud_if.sv
// Handshake interfaces for page references in and replacement results out.
// Depends on lrud_pkg.
interface lrud_req_if import lrud_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PageW-1:0] page_number;
  logic             is_write;

  modport source (output valid, page_number, is_write, input ready);
  modport sink   (input valid, page_number, is_write, output ready);
endinterface

interface lrud_rsp_if import lrud_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted_valid;
  logic [PageW-1:0] evicted_page;
  logic             evicted_dirty;
  tot_t             hit_total;
  tot_t             fault_total;
  tot_t             writeback_total;

  modport source (output valid, hit, evicted_valid, evicted_page, evicted_dirty,
                  hit_total, fault_total, writeback_total, input ready);
  modport sink   (input valid, hit, evicted_valid, evicted_page, evicted_dirty,
                  hit_total, fault_total, writeback_total, output ready);
endinterface

>>> design/lrud_ctrl.sv
// Controller: sequences lookup and commit of one item, owns the result valid.
// Depends on lrud_pkg.
module lrud_ctrl import lrud_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StLook = 3'b010,
    StUpd  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_commit, accept;

  assign can_commit  = (state_q == StUpd) && (!out_valid_q || rsp_ready_i);
  assign req_ready_o = (state_q == StIdle) || can_commit;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StLook;
      StLook: state_d = StUpd;
      StUpd: begin
        if (can_commit) state_d = accept ? StLook : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (can_commit) out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hit status is not needed for sequencing; hits and misses both pass through the same commit state
  logic unused_hit;
  assign unused_hit = sts_i.look_hit;

  assign rsp_valid_o    = out_valid_q;
  assign cmd_o.capture  = accept;
  assign cmd_o.look     = (state_q == StLook) && !unused_hit | (state_q == StLook);
  assign cmd_o.commit   = can_commit;

endmodule

>>> design/lrud_dpath.sv
// Datapath: frame tags, dirty and recency state, counters and result register.
// Depends on lrud_pkg.
module lrud_dpath import lrud_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic [PageW-1:0] page_number_i,
  input  logic            is_write_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic [CfgW-1:0] frame_limit_o,
  output rsp_t            rsp_o
);

  tag_t            page_q;
  logic            wr_q;
  logic [CfgW-1:0] frame_limit_q;

  tag_t              tags_q [Frames];
  logic [Frames-1:0] valid_q, valid_d;
  logic [Frames-1:0] dirty_q, dirty_d;
  idx_t              rank_q [Frames];
  idx_t              rank_d [Frames];
  cnt_t              count_q, count_d;
  tot_t              hits_q, faults_q, wbs_q;
  tot_t              hits_d, faults_d, wbs_d;

  logic hit_q, evict_q;
  idx_t found_q, victim_q;
  rsp_t rsp_q;

  // lookup
  logic [Frames-1:0] match;
  logic              hit_c, evict_c;
  idx_t              found_c, victim_c;
  cnt_t              usable, last;

  always_comb begin
    usable = CntW'(frame_limit_q);
    if (frame_limit_q == '0) usable = CntW'(1);
    else if (32'(frame_limit_q) > Frames) usable = CntW'(Frames);
  end

  assign last = count_q - CntW'(1);

  always_comb begin
    found_c  = '0;
    victim_c = '0;
    for (int i = Frames - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (tags_q[i] == page_q);
      if (match[i]) found_c = IdxW'(i);
      if (valid_q[i] && (CntW'(rank_q[i]) == last)) victim_c = IdxW'(i);
    end
  end

  assign hit_c   = |match;
  assign evict_c = !hit_c && (count_q >= usable) && (count_q != '0);
  assign sts_o.look_hit = hit_c;

  // commit
  logic [Frames-1:0] valid_ev;
  idx_t              slot;
  idx_t              r;
  logic              wb;

  assign r  = rank_q[found_q];
  assign wb = evict_q && dirty_q[victim_q];

  always_comb begin
    valid_ev = valid_q;
    if (evict_q) valid_ev[victim_q] = 1'b0;
    slot = '0;
    for (int i = Frames - 1; i >= 0; i--) begin
      if (!valid_ev[i]) slot = IdxW'(i);
    end
  end

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    count_d = count_q;
    for (int i = 0; i < Frames; i++) rank_d[i] = rank_q[i];
    if (hit_q) begin
      for (int i = 0; i < Frames; i++) begin
        if (valid_q[i] && (rank_q[i] < r)) rank_d[i] = rank_q[i] + IdxW'(1);
      end
      rank_d[found_q] = '0;
      if (wr_q) dirty_d[found_q] = 1'b1;
    end else begin
      for (int i = 0; i < Frames; i++) begin
        if (valid_ev[i]) rank_d[i] = rank_q[i] + IdxW'(1);
      end
      if (evict_q) begin
        valid_d[victim_q] = 1'b0;
        dirty_d[victim_q] = 1'b0;
        rank_d[victim_q]  = '0;
      end
      valid_d[slot] = 1'b1;
      dirty_d[slot] = wr_q;
      rank_d[slot]  = '0;
      count_d = count_q - CntW'(evict_q) + CntW'(1);
    end
  end

  assign hits_d   = hits_q + TotW'(hit_q);
  assign faults_d = faults_q + TotW'(!hit_q);
  assign wbs_d    = wbs_q + TotW'(wb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= CfgW'(16);
      valid_q       <= '0;
      dirty_q       <= '0;
      count_q       <= '0;
      hits_q        <= '0;
      faults_q      <= '0;
      wbs_q         <= '0;
      for (int i = 0; i < Frames; i++) rank_q[i] <= '0;
    end else begin
      if (cfg_we_i) frame_limit_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        valid_q  <= valid_d;
        dirty_q  <= dirty_d;
        count_q  <= count_d;
        hits_q   <= hits_d;
        faults_q <= faults_d;
        wbs_q    <= wbs_d;
        for (int i = 0; i < Frames; i++) rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_number_i[PageBits-1:0];
      wr_q   <= is_write_i;
    end
    if (cmd_i.look) begin
      hit_q    <= hit_c;
      evict_q  <= evict_c;
      found_q  <= found_c;
      victim_q <= victim_c;
    end
    if (cmd_i.commit && !hit_q) tags_q[slot] <= page_q;
    if (cmd_i.commit) begin
      rsp_q.hit             <= hit_q;
      rsp_q.evicted_valid   <= evict_q;
      rsp_q.evicted_page    <= evict_q ? PageW'(tags_q[victim_q]) : '0;
      rsp_q.evicted_dirty   <= wb;
      rsp_q.hit_total       <= hits_d;
      rsp_q.fault_total     <= faults_d;
      rsp_q.writeback_total <= wbs_d;
    end
  end

  assign frame_limit_o = frame_limit_q;
  assign rsp_o         = rsp_q;

endmodule

>>> design/lru_page_replacer_dirty.sv
// Top level of the LRU page replacer with dirty marks: APB register, controller, datapath.
// Depends on lrud_pkg, lrud_if, lrud_ctrl and lrud_dpath.
//
//   channel  dir  handshake        payload
//   req_i    in   valid/ready      page_number[19:0], is_write
//   rsp_o    out  valid/ready      hit, evicted_*, hit/fault/writeback totals
//   apb      in   psel/penable     frame_limit at byte address 0
//
// Each item passes through a tag lookup state over all 16 frames, then a
// commit state that updates recency, dirty marks and counters.
// A new item is taken in the commit cycle of the previous one.
// A held result stalls the commit cycle until the result register is free.
// Reset clears all frames and counters; frame_limit returns to 16.
module lru_page_replacer_dirty import lrud_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  lrud_req_if.sink         req_i,
  lrud_rsp_if.source       rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cmd_t            cmd;
  sts_t            sts;
  rsp_t            rsp;
  logic [CfgW-1:0] frame_limit;
  logic            cfg_we;
  logic [RegIdxW-1:0] reg_idx;

  assign reg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && (reg_idx == RegFrameLimit);

  always_comb begin
    unique case (reg_idx)
      RegFrameLimit: prdata = DataW'(frame_limit);
      default:       prdata = '0;
    endcase
  end

  lrud_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lrud_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .page_number_i (req_i.page_number),
    .is_write_i    (req_i.is_write),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[CfgW-1:0]),
    .frame_limit_o (frame_limit),
    .rsp_o         (rsp)
  );

  assign rsp_o.hit             = rsp.hit;
  assign rsp_o.evicted_valid   = rsp.evicted_valid;
  assign rsp_o.evicted_page    = rsp.evicted_page;
  assign rsp_o.evicted_dirty   = rsp.evicted_dirty;
  assign rsp_o.hit_total       = rsp.hit_total;
  assign rsp_o.fault_total     = rsp.fault_total;
  assign rsp_o.writeback_total = rsp.writeback_total;

endmodule

>>> design/lrud_chk.sv
// Port-level checker for the LRU page replacer, bound to the top level.
// Depends on lrud_pkg.
module lrud_chk import lrud_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic             hit_i,
  input logic             evicted_valid_i,
  input logic [PageW-1:0] evicted_page_i,
  input logic             evicted_dirty_i,
  input tot_t             hit_total_i
);

  // one item in flight: the lookup cycle never takes another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("item taken during lookup");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && hit_i) |-> !evicted_valid_i)
    else $error("eviction reported on a hit");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !evicted_valid_i) |-> (evicted_page_i == '0 && !evicted_dirty_i))
    else $error("eviction fields set without eviction");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(hit_total_i)
      && $stable(evicted_page_i)))
    else $error("stalled result changed");

endmodule

bind lru_page_replacer_dirty lrud_chk u_lrud_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .hit_i           (rsp_o.hit),
  .evicted_valid_i (rsp_o.evicted_valid),
  .evicted_page_i  (rsp_o.evicted_page),
  .evicted_dirty_i (rsp_o.evicted_dirty),
  .hit_total_i     (rsp_o.hit_total)
);
